/* rtl/csc_pkg.sv */
// Shared widths, constants, arctangent table and pipeline record types for the
// cylindrical scan to Cartesian converter. No dependencies.
package csc_pkg;

    // Fixed-point formats.
    localparam int FRAC_BITS   = 16;
    localparam int ANGLE_FRAC  = 24;
    localparam int GUARD_BITS  = 8;
    localparam int TABLE_LEN   = 24;
    localparam int ANG_SHIFT   = ANGLE_FRAC - FRAC_BITS;

    // Port field widths.
    localparam int AXIS_W   = 31;
    localparam int OFFSET_W = 32;
    localparam int TURN_W   = 35;
    localparam int HEIGHT_W = 32;
    localparam int POS_W    = 33;
    localparam int ROW_W    = 11;
    localparam int IDX_W    = 20;
    localparam int CNT_MAX_W = 32;

    // Radius and magnitude.
    localparam int RAD_W  = 33;
    localparam int MAG_W  = 32;

    // One row spans 360 << FRAC_BITS = 45 << (FRAC_BITS + 3).
    localparam int ROW_SHIFT   = FRAC_BITS + 3;
    localparam int TQ_W        = TURN_W - ROW_SHIFT;
    localparam int ROW_DIV     = 45;
    localparam int REM_W       = 6;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 27;
    localparam logic [RECIP_W-1:0] ROW_RECIP = RECIP_W'(2982617);

    // Gain correction, 0.60725293500888 in Q30, result keeps GUARD_BITS extra bits.
    localparam int GAIN_W     = 30;
    localparam int GAIN_SHIFT = 22;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032874);
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int X0_W   = PROD_W - GAIN_SHIFT;

    // Rotation datapath widths.
    localparam int CW   = 43;
    localparam int ZW   = 34;
    localparam int RX_W = CW - GUARD_BITS;

    localparam logic [AXIS_W-1:0] AXIS_RESET = AXIS_W'(64'd250 << FRAC_BITS);

    localparam int DEFAULT_STAGES     = 18;
    localparam int DEFAULT_INDEX_BITS = 20;
    localparam int Q_DEPTH            = 4;

    // atan(2^-i) in degrees, Q24, rounded.
    localparam logic [29:0] ATAN_TAB [TABLE_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234683,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115
    };

    // Fields that ride alongside the rotation unchanged.
    typedef struct packed {
        logic                       neg;
        logic [ROW_W-1:0]           row;
        logic                       started;
        logic [IDX_W-1:0]           idx;
        logic signed [HEIGHT_W-1:0] height;
    } csc_side_t;

    // One classified sample handed from the front end to the rotator.
    typedef struct packed {
        csc_side_t            side;
        logic signed [CW-1:0] x;
        logic signed [ZW-1:0] z;
    } csc_item_t;

endpackage

/* rtl/cylindrical_scan_to_cartesian_core.sv */
// Path: a sample passes the front stages, the queue, the rotation stages, the
// rounding register and the output register before its result shows on m_valid.
// Throughput: one sample per cycle while the result side keeps taking results; a
// four-entry queue between the front end and the CORDIC pipeline absorbs stalls.
// Reset: aresetn is synchronous and active low; it empties all stages, clears the row
// and point counters and loads axis_radius with 250.0 (16 fraction bits).
module cylindrical_scan_to_cartesian_core
    import csc_pkg::*;
#(
    parameter int ROTATION_STAGES = DEFAULT_STAGES,
    parameter int INDEX_BITS      = DEFAULT_INDEX_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [AXIS_W-1:0]          cfg_axis_radius,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [OFFSET_W-1:0] s_radial_offset,
    input  logic [TURN_W-1:0]          s_turn_angle,
    input  logic signed [HEIGHT_W-1:0] s_height,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POS_W-1:0]    m_pos_x,
    output logic signed [POS_W-1:0]    m_pos_y,
    output logic signed [HEIGHT_W-1:0] m_pos_z,
    output logic [ROW_W-1:0]           m_row_number,
    output logic                       m_row_started,
    output logic [IDX_W-1:0]           m_point_index
);

    // The front end takes one beat per cycle unless its last stage is blocked. In three stages it forms the radius
    // (axis distance minus offset), splits the turn angle into a row number and an
    // in-row angle by a reciprocal multiply, updates the row tracker and the point
    // counter, applies the CORDIC gain correction to the radius magnitude and folds
    // the angle into the range of convergence.
    logic      push;
    logic      q_full;
    csc_item_t push_item;
    logic      pop;
    logic      q_avail;
    csc_item_t pop_item;

    csc_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_axis_radius (cfg_axis_radius),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_radial_offset (s_radial_offset),
        .s_turn_angle    (s_turn_angle),
        .s_height        (s_height),
        .push            (push),
        .push_item       (push_item),
        .q_full          (q_full)
    );

    // The queue decouples the two halves, so a stall at the result side only
    // reaches the sample side once the queue has filled.
    csc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .avail     (q_avail)
    );

    // The back end runs one CORDIC micro-rotation per stage, then rounds away the
    // guard bits, restores the sign of a negative radius, saturates to the output
    // width and holds the result beat until it is taken.
    csc_cordic #(
        .ROTATION_STAGES (ROTATION_STAGES)
    ) u_cordic (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_item      (pop_item),
        .avail         (q_avail),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_pos_z       (m_pos_z),
        .m_row_number  (m_row_number),
        .m_row_started (m_row_started),
        .m_point_index (m_point_index)
    );

endmodule

/* rtl/csc_front.sv */
// Front end: configuration register, radius, row split, row tracking, point
// numbering, gain correction and quadrant fold. Depends on csc_pkg.
module csc_front
    import csc_pkg::*;
#(
    parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [AXIS_W-1:0]          cfg_axis_radius,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [OFFSET_W-1:0] s_radial_offset,
    input  logic [TURN_W-1:0]          s_turn_angle,
    input  logic signed [HEIGHT_W-1:0] s_height,
    output logic                       push,
    output csc_item_t                  push_item,
    input  logic                       q_full
);

    localparam logic [ZW-1:0] Z90  = ZW'(64'd90 << ANGLE_FRAC);
    localparam logic [ZW-1:0] Z180 = ZW'(64'd180 << ANGLE_FRAC);
    localparam logic [ZW-1:0] Z270 = ZW'(64'd270 << ANGLE_FRAC);
    localparam logic [ZW-1:0] Z360 = ZW'(64'd360 << ANGLE_FRAC);

    logic [AXIS_W-1:0] axis_radius_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [INDEX_BITS-1:0] cnt_reg;

    logic                       f1_valid_reg;
    logic signed [RAD_W-1:0]    f1_rad_reg;
    logic [ROW_W-1:0]           f1_row_reg;
    logic [TQ_W-1:0]            f1_tq_reg;
    logic [ROW_SHIFT-1:0]       f1_lo_reg;
    logic signed [HEIGHT_W-1:0] f1_height_reg;

    logic                 f2_valid_reg;
    logic [MAG_W-1:0]     f2_mag_reg;
    logic [REM_W-1:0]     f2_rem_reg;
    logic [ROW_SHIFT-1:0] f2_lo_reg;
    csc_side_t            f2_side_reg;

    logic                 f3_valid_reg;
    logic [X0_W-1:0]      f3_x0_reg;
    logic                 f3_xneg_reg;
    logic signed [ZW-1:0] f3_z_reg;
    csc_side_t            f3_side_reg;

    logic                    en;
    logic signed [RAD_W-1:0] rad;
    logic [TQ_W+RECIP_W-1:0] row_prod;
    logic [RAD_W-1:0]        rad_u;
    logic [RAD_W-1:0]        mag_full;
    logic [TQ_W-1:0]         row_x45;
    logic [TQ_W-1:0]         rem_full;
    logic                    started;
    logic [CNT_MAX_W-1:0]    cnt_wide;
    logic [PROD_W-1:0]       gain_prod;
    logic [PROD_W-1:0]       gain_rnd;
    logic [ZW-1:0]           za;
    logic [ZW-1:0]           z_next;
    logic                    xneg_next;
    logic [CW-1:0]           x_ext;
    logic [CW-1:0]           x_start;

    // The whole front pipeline moves as one unless its last stage is blocked.
    assign en        = !f3_valid_reg || !q_full;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Stage 1 arithmetic.
    assign rad = $signed({2'b00, axis_radius_reg})
               - $signed({s_radial_offset[OFFSET_W-1], s_radial_offset});
    assign row_prod = (TQ_W+RECIP_W)'(s_turn_angle[TURN_W-1:ROW_SHIFT])
                    * (TQ_W+RECIP_W)'(ROW_RECIP);

    // Stage 2 arithmetic.
    assign rad_u    = f1_rad_reg;
    assign mag_full = f1_rad_reg[RAD_W-1] ? (RAD_W'(0) - rad_u) : rad_u;
    assign row_x45  = TQ_W'(f1_row_reg) * TQ_W'(ROW_DIV);
    assign rem_full = f1_tq_reg - row_x45;
    assign started  = f1_row_reg > cur_row_reg;
    assign cnt_wide = CNT_MAX_W'(cnt_reg);

    // Stage 3 arithmetic.
    assign gain_prod = PROD_W'(f2_mag_reg) * PROD_W'(GAIN_Q30);
    assign gain_rnd  = gain_prod + (PROD_W'(1) << (GAIN_SHIFT - 1));
    assign za        = {1'b0, f2_rem_reg, f2_lo_reg, {ANG_SHIFT{1'b0}}};

    always_comb begin
        xneg_next = 1'b0;
        z_next    = za;
        if (za >= Z270) begin
            z_next = za - Z360;
        end else if (za >= Z90) begin
            z_next    = za - Z180;
            xneg_next = 1'b1;
        end
    end

    assign x_ext   = CW'(f3_x0_reg);
    assign x_start = f3_xneg_reg ? (CW'(0) - x_ext) : x_ext;

    assign push           = f3_valid_reg && !q_full;
    assign push_item.side = f3_side_reg;
    assign push_item.x    = $signed(x_start);
    assign push_item.z    = f3_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_radius_reg <= AXIS_RESET;
            cur_row_reg     <= '0;
            cnt_reg         <= '0;
            f1_valid_reg    <= 1'b0;
            f2_valid_reg    <= 1'b0;
            f3_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                axis_radius_reg <= cfg_axis_radius;
            end
            if (en) begin
                f1_valid_reg <= s_valid;
                f2_valid_reg <= f1_valid_reg;
                f3_valid_reg <= f2_valid_reg;
                if (f1_valid_reg) begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (started) begin
                        cur_row_reg <= f1_row_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_rad_reg    <= rad;
            f1_row_reg    <= row_prod[RECIP_SHIFT +: ROW_W];
            f1_tq_reg     <= s_turn_angle[TURN_W-1:ROW_SHIFT];
            f1_lo_reg     <= s_turn_angle[ROW_SHIFT-1:0];
            f1_height_reg <= s_height;

            f2_mag_reg          <= mag_full[MAG_W-1:0];
            f2_rem_reg          <= rem_full[REM_W-1:0];
            f2_lo_reg           <= f1_lo_reg;
            f2_side_reg.neg     <= f1_rad_reg[RAD_W-1];
            f2_side_reg.row     <= f1_row_reg;
            f2_side_reg.started <= started;
            f2_side_reg.idx     <= cnt_wide[IDX_W-1:0];
            f2_side_reg.height  <= f1_height_reg;

            f3_x0_reg   <= gain_rnd[GAIN_SHIFT +: X0_W];
            f3_xneg_reg <= xneg_next;
            f3_z_reg    <= $signed(z_next);
            f3_side_reg <= f2_side_reg;
        end
    end

endmodule

/* rtl/csc_queue.sv */
// Short FIFO of classified samples between the front end and the rotator.
// Depends on csc_pkg.
module csc_queue
    import csc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  csc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output csc_item_t pop_item,
    output logic      avail
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    csc_item_t        mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full     = count_reg == (PTR_W+1)'(Q_DEPTH);
    assign avail    = count_reg != '0;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(Q_DEPTH))
        else $error("queue count above depth");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue pushed while full");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone push");
`endif

endmodule

/* rtl/csc_cordic.sv */
// Back end: pipelined CORDIC rotation, rounding, sign restore, saturation and
// the result register. Depends on csc_pkg.
module csc_cordic
    import csc_pkg::*;
#(
    parameter int ROTATION_STAGES = DEFAULT_STAGES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  csc_item_t                  pop_item,
    input  logic                       avail,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POS_W-1:0]    m_pos_x,
    output logic signed [POS_W-1:0]    m_pos_y,
    output logic signed [HEIGHT_W-1:0] m_pos_z,
    output logic [ROW_W-1:0]           m_row_number,
    output logic                       m_row_started,
    output logic [IDX_W-1:0]           m_point_index
);

    localparam int STAGES = (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;
    localparam logic signed [CW-1:0] RND = CW'(1 << (GUARD_BITS - 1));
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    logic signed [CW-1:0] x_reg [STAGES];
    logic signed [CW-1:0] y_reg [STAGES];
    logic signed [ZW-1:0] z_reg [STAGES];
    csc_side_t            side_reg [STAGES];
    logic                 v_reg [STAGES];

    logic signed [CW-1:0] x_src [STAGES];
    logic signed [CW-1:0] y_src [STAGES];
    logic signed [ZW-1:0] z_src [STAGES];
    logic signed [CW-1:0] x_next [STAGES];
    logic signed [CW-1:0] y_next [STAGES];
    logic signed [ZW-1:0] z_next [STAGES];

    logic                   rnd_valid_reg;
    logic signed [RX_W-1:0] rnd_x_reg;
    logic signed [RX_W-1:0] rnd_y_reg;
    csc_side_t              rnd_side_reg;

    logic                   out_valid_reg;
    logic signed [POS_W-1:0] out_x_reg;
    logic signed [POS_W-1:0] out_y_reg;
    csc_side_t              out_side_reg;

    logic                   en;
    logic [CW-1:0]          sum_x;
    logic [CW-1:0]          sum_y;
    logic signed [RX_W:0]   nx;
    logic signed [RX_W:0]   ny;
    logic signed [POS_W-1:0] sat_x;
    logic signed [POS_W-1:0] sat_y;

    // The back pipeline stalls as a whole only while a result waits unread.
    assign en  = !out_valid_reg || m_ready;
    assign pop = en && avail;

    always_comb begin
        x_src[0] = pop_item.x;
        y_src[0] = '0;
        z_src[0] = pop_item.z;
        for (int k = 1; k < STAGES; k++) begin
            x_src[k] = x_reg[k-1];
            y_src[k] = y_reg[k-1];
            z_src[k] = z_reg[k-1];
        end
        for (int k = 0; k < STAGES; k++) begin
            if (!z_src[k][ZW-1]) begin
                x_next[k] = x_src[k] - (y_src[k] >>> k);
                y_next[k] = y_src[k] + (x_src[k] >>> k);
                z_next[k] = z_src[k] - $signed(ZW'(ATAN_TAB[k]));
            end else begin
                x_next[k] = x_src[k] + (y_src[k] >>> k);
                y_next[k] = y_src[k] - (x_src[k] >>> k);
                z_next[k] = z_src[k] + $signed(ZW'(ATAN_TAB[k]));
            end
        end
    end

    assign sum_x = x_reg[STAGES-1] + RND;
    assign sum_y = y_reg[STAGES-1] + RND;

    assign nx = rnd_side_reg.neg ? -$signed({rnd_x_reg[RX_W-1], rnd_x_reg})
                                 : $signed({rnd_x_reg[RX_W-1], rnd_x_reg});
    assign ny = rnd_side_reg.neg ? -$signed({rnd_y_reg[RX_W-1], rnd_y_reg})
                                 : $signed({rnd_y_reg[RX_W-1], rnd_y_reg});

    always_comb begin
        if ((&nx[RX_W:POS_W-1]) || !(|nx[RX_W:POS_W-1])) begin
            sat_x = nx[POS_W-1:0];
        end else begin
            sat_x = nx[RX_W] ? POS_MIN : POS_MAX;
        end
        if ((&ny[RX_W:POS_W-1]) || !(|ny[RX_W:POS_W-1])) begin
            sat_y = ny[POS_W-1:0];
        end else begin
            sat_y = ny[RX_W] ? POS_MIN : POS_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STAGES; k++) begin
                v_reg[k] <= 1'b0;
            end
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= avail;
            for (int k = 1; k < STAGES; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
            rnd_valid_reg <= v_reg[STAGES-1];
            out_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STAGES; k++) begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            side_reg[0] <= pop_item.side;
            for (int k = 1; k < STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            rnd_x_reg    <= $signed(sum_x[CW-1:GUARD_BITS]);
            rnd_y_reg    <= $signed(sum_y[CW-1:GUARD_BITS]);
            rnd_side_reg <= side_reg[STAGES-1];
            out_x_reg    <= sat_x;
            out_y_reg    <= sat_y;
            out_side_reg <= rnd_side_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pos_x       = out_x_reg;
    assign m_pos_y       = out_y_reg;
    assign m_pos_z       = out_side_reg.height;
    assign m_row_number  = out_side_reg.row;
    assign m_row_started = out_side_reg.started;
    assign m_point_index = out_side_reg.idx;

endmodule
